### src/rsec_pkg.sv
`timescale 1ns / 1ps
package rsec_pkg;

  localparam int unsigned DataBytesDef    = 4096;
  localparam int unsigned ZeroRunLimitDef = 5;

  localparam logic [6:0] OPC_NONE   = 7'h00;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;

  localparam logic [2:0] F3_ADD  = 3'h0;
  localparam logic [2:0] F3_XOR  = 3'h4;
  localparam logic [2:0] F3_SRA  = 3'h5;
  localparam logic [2:0] F3_ANDI = 3'h7;
  localparam logic [2:0] F3_BLT  = 3'h4;
  localparam logic [2:0] F3_JALR = 3'h0;
  localparam logic [2:0] F3_WORD = 3'h2;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [31:0] addr;
    logic [31:0] wdata;
  } dmem_req_t;

endpackage

### src/rsec_regfile.sv
`timescale 1ns / 1ps
module rsec_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [4:0]  raddr_a_i,
  input  logic [4:0]  raddr_b_i,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o
);
  logic [31:0] mem [32];
  logic [31:0] valid_q;
  logic [4:0]  raddr_a_q;
  logic [4:0]  raddr_b_q;
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
      raddr_a_q <= raddr_a_i;
      raddr_b_q <= raddr_b_i;
    end
  end

  assign rdata_a_o = valid_q[raddr_a_q] ? rdata_a_q : 32'd0;
  assign rdata_b_o = valid_q[raddr_b_q] ? rdata_b_q : 32'd0;

endmodule

### src/rsec_dstore.sv
`timescale 1ns / 1ps
module rsec_dstore #(
  parameter int unsigned DATA_BYTES = rsec_pkg::DataBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsec_pkg::dmem_req_t req_i,
  output logic                busy_o,
  output logic [31:0]         rdata_o
);
  import rsec_pkg::*;

  localparam int unsigned AW   = $clog2(DATA_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = DATA_BYTES / 4;

  logic             clr_busy_q;
  logic [RW-1:0]    clr_row_q;
  logic [1:0]       off;
  logic [1:0]       off_q;
  logic [RW-1:0]    row;
  logic [3:0][7:0]  lane_data;

  assign off = req_i.addr[1:0];
  assign row = req_i.addr[AW-1:2];
  assign busy_o = clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      clr_row_q <= clr_row_q + RW'(1);
      if (clr_row_q == RW'(ROWS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      off_q <= off;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam logic [1:0] LANE = 2'(l);
    logic [7:0]    mem [ROWS];
    logic [RW-1:0] lane_row;
    logic [1:0]    sel;
    logic [7:0]    wbyte;
    logic [7:0]    rd_q;

    assign lane_row = row + ((LANE < off) ? RW'(1) : RW'(0));
    assign sel      = LANE - off;
    assign wbyte    = req_i.wdata[{sel, 3'b000} +: 8];

    always_ff @(posedge clk_i) begin
      if (clr_busy_q) begin
        mem[clr_row_q] <= 8'd0;
      end else if (req_i.wr_en) begin
        mem[lane_row] <= wbyte;
      end
      if (req_i.rd_en) begin
        rd_q <= mem[lane_row];
      end
    end

    assign lane_data[l] = rd_q;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = lane_data[2'(off_q + 2'(i))];
    end
  end

endmodule

### src/rv32i_subset_executor_unit.sv
`timescale 1ns / 1ps
// Pipeline: an accepted instruction word is registered together with its register file operands,
// and its result is registered at the outputs when it fires; lw also passes a load return stage,
// where the word read from the synchronous data store is registered before the result goes out.
// Throughput: one word per cycle while the output is not stalled; a lw stalls input in execute.
// Reset: registers, PC and counters clear at once; the data store is then cleared one row
// of four bytes per cycle, DATA_BYTES/4 rows, while in_stall_o stays high.
module rv32i_subset_executor_unit #(
  parameter int unsigned DATA_BYTES     = rsec_pkg::DataBytesDef,
  parameter int unsigned ZERO_RUN_LIMIT = rsec_pkg::ZeroRunLimitDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instr_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        next_pc_o,
  output logic               wrote_reg_o,
  output logic [4:0]         dest_index_o,
  output logic signed [31:0] dest_value_o,
  output logic               illegal_o,
  output logic               finished_o,
  output logic signed [31:0] reg_a0_o,
  output logic signed [31:0] reg_a1_o,
  output logic [31:0]        instr_count_o
);
  import rsec_pkg::*;

  localparam int unsigned ZRW = $clog2(ZERO_RUN_LIMIT + 1);

  logic        accept;
  logic        out_free;
  logic        x_valid_q;
  logic [31:0] instr_q;
  logic        m_valid_q;
  logic [4:0]  m_rd_q;
  logic [31:0] m_npc_q;
  logic [31:0] pc_q;
  logic [ZRW-1:0] zr_q;
  logic [ZRW-1:0] zr_d;
  logic [31:0] cnt_q;
  logic [31:0] cnt_d;
  logic [31:0] a0_q;
  logic [31:0] a1_q;
  logic [31:0] a0_d;
  logic [31:0] a1_d;
  logic        fwd_valid_q;
  logic [4:0]  fwd_idx_q;
  logic [31:0] fwd_val_q;
  logic        out_valid_q;

  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic        store_busy;
  logic [31:0] load_data;
  dmem_req_t   dreq;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;

  logic        x_is_load;
  logic        x_is_store;
  logic        x_fire;
  logic        m_fire;
  logic        fire;
  logic [31:0] x_npc;
  logic [31:0] x_val;
  logic        x_wr;
  logic        x_ill;
  logic        x_known;

  logic [31:0] f_npc;
  logic        f_wr;
  logic [4:0]  f_rd;
  logic [31:0] f_val;
  logic        f_ill;
  logic        f_known;
  logic        f_zero;

  assign opc   = instr_q[6:0];
  assign f3    = instr_q[14:12];
  assign f7    = instr_q[31:25];
  assign rd    = instr_q[11:7];
  assign rs1   = instr_q[19:15];
  assign rs2   = instr_q[24:20];
  assign imm_i = {{20{instr_q[31]}}, instr_q[31:20]};
  assign imm_s = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
  assign imm_b = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
                  instr_q[11:8], 1'b0};

  assign op_a = (fwd_valid_q && fwd_idx_q == rs1) ? fwd_val_q : rf_a;
  assign op_b = (fwd_valid_q && fwd_idx_q == rs2) ? fwd_val_q : rf_b;

  always_comb begin
    x_npc   = pc_q + 32'd4;
    x_val   = 32'd0;
    x_wr    = 1'b0;
    x_ill   = 1'b0;
    x_known = 1'b1;
    case (opc)
      OPC_REG: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          x_val = op_a + op_b;
          x_wr  = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          x_val = op_a - op_b;
          x_wr  = 1'b1;
        end else if (f3 == F3_XOR && f7 == F7_BASE) begin
          x_val = op_a ^ op_b;
          x_wr  = 1'b1;
        end else if (f3 == F3_SRA && f7 == F7_ALT) begin
          x_val = 32'($signed(op_a) >>> op_b[4:0]);
          x_wr  = 1'b1;
        end else begin
          x_ill = 1'b1;
        end
      end
      OPC_IMM: begin
        if (f3 == F3_ADD) begin
          x_val = op_a + imm_i;
          x_wr  = 1'b1;
        end else if (f3 == F3_ANDI) begin
          x_val = op_a & imm_i;
          x_wr  = 1'b1;
        end else begin
          x_ill = 1'b1;
        end
      end
      OPC_BRANCH: begin
        if (f3 == F3_BLT) begin
          if ($signed(op_a) < $signed(op_b)) begin
            x_npc = pc_q + imm_b;
          end
        end else begin
          x_ill = 1'b1;
        end
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          x_val = pc_q + 32'd4;
          x_wr  = 1'b1;
          x_npc = (op_a + imm_i) & ~32'd1;
        end else begin
          x_ill = 1'b1;
        end
      end
      OPC_LOAD: begin
        if (f3 == F3_WORD) begin
          x_wr = 1'b1;
        end else begin
          x_ill = 1'b1;
        end
      end
      OPC_STORE: begin
        if (f3 != F3_WORD) begin
          x_ill = 1'b1;
        end
      end
      OPC_NONE: begin
        x_known = 1'b0;
      end
      default: begin
        x_ill = 1'b1;
      end
    endcase
    if (x_ill) begin
      x_known = 1'b0;
      x_wr    = 1'b0;
    end
  end

  assign x_is_load  = x_valid_q && opc == OPC_LOAD && f3 == F3_WORD;
  assign x_is_store = opc == OPC_STORE && f3 == F3_WORD;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign m_fire     = m_valid_q && out_free;
  assign x_fire     = x_valid_q && !x_is_load && !m_valid_q && out_free;
  assign fire       = x_fire || m_fire;

  assign in_stall_o = store_busy || (m_valid_q && !m_fire) || (x_valid_q && !x_fire);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (m_valid_q) begin
      f_npc   = m_npc_q;
      f_wr    = m_rd_q != 5'd0;
      f_rd    = m_rd_q;
      f_val   = load_data;
      f_ill   = 1'b0;
      f_known = 1'b1;
      f_zero  = 1'b0;
    end else begin
      f_npc   = x_npc;
      f_wr    = x_wr && rd != 5'd0;
      f_rd    = rd;
      f_val   = x_val;
      f_ill   = x_ill;
      f_known = x_known;
      f_zero  = instr_q[14:0] == 15'd0;
    end
    if (!f_wr) begin
      f_rd  = 5'd0;
      f_val = 32'd0;
    end
  end

  always_comb begin
    if (!f_zero) begin
      zr_d = '0;
    end else if (zr_q < ZRW'(ZERO_RUN_LIMIT)) begin
      zr_d = zr_q + ZRW'(1);
    end else begin
      zr_d = zr_q;
    end
    cnt_d = (f_known && cnt_q != 32'hFFFF_FFFF) ? cnt_q + 32'd1 : cnt_q;
    a0_d  = (f_wr && f_rd == 5'd10) ? f_val : a0_q;
    a1_d  = (f_wr && f_rd == 5'd11) ? f_val : a1_q;
  end

  assign dreq.rd_en = x_is_load;
  assign dreq.wr_en = x_fire && x_is_store;
  assign dreq.addr  = op_a + (x_is_store ? imm_s : imm_i);
  assign dreq.wdata = op_b;

  rsec_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .raddr_a_i (instr_word_i[19:15]),
    .raddr_b_i (instr_word_i[24:20]),
    .we_i      (fire && f_wr),
    .waddr_i   (f_rd),
    .wdata_i   (f_val),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  rsec_dstore #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dstore (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dreq),
    .busy_o  (store_busy),
    .rdata_o (load_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      pc_q        <= '0;
      zr_q        <= '0;
      cnt_q       <= '0;
      a0_q        <= '0;
      a1_q        <= '0;
    end else begin
      if (accept) begin
        x_valid_q <= 1'b1;
      end else if (x_fire || x_is_load) begin
        x_valid_q <= 1'b0;
      end
      if (x_is_load) begin
        m_valid_q <= 1'b1;
      end else if (m_fire) begin
        m_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        pc_q  <= f_npc;
        zr_q  <= zr_d;
        cnt_q <= cnt_d;
        a0_q  <= a0_d;
        a1_q  <= a1_d;
        if (f_wr) begin
          fwd_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instr_word_i;
    end
    if (x_is_load) begin
      m_rd_q  <= rd;
      m_npc_q <= pc_q + 32'd4;
    end
    if (fire && f_wr) begin
      fwd_idx_q <= f_rd;
      fwd_val_q <= f_val;
    end
    if (fire) begin
      next_pc_o     <= f_npc;
      wrote_reg_o   <= f_wr;
      dest_index_o  <= f_rd;
      dest_value_o  <= f_val;
      illegal_o     <= f_ill;
      finished_o    <= zr_d >= ZRW'(ZERO_RUN_LIMIT);
      reg_a0_o      <= a0_d;
      reg_a1_o      <= a1_d;
      instr_count_o <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_load_or_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !x_valid_q)
    else $error("load return and execute stage both occupied");
  a_load_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_is_load |=> m_valid_q)
    else $error("load did not move to the return stage");
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && f_wr) |-> f_rd != 5'd0)
    else $error("write to register zero");
  a_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_fire) |=> m_valid_q && $stable(m_rd_q))
    else $error("pending load lost its destination");
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !x_valid_q && !m_valid_q)
    else $error("instruction in flight during data store clearing");
`endif

endmodule
